>>> hw/rtl/gds_pkg.sv
// ----------------------------------------------------------------------------
// gds_pkg: shared types, constants and functions for the date stepper
// Holds the operation codes, calendar limits, the controller-to-datapath
// command and status structs, and the month length function.
// ----------------------------------------------------------------------------
package gds_pkg;

    // Field widths.
    localparam int OP_W    = 2;
    localparam int COUNT_W = 16;
    localparam int YEAR_W  = 14;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    // Year within a century and century number (both 0..99 for valid years).
    localparam int CENT_W  = 7;
    // Quotient of a 14-bit year by 100 (up to 163).
    localparam int QUOT_W  = 8;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_LOAD = 2'd0;
    localparam logic [OP_W-1:0] OP_ADV  = 2'd1;
    localparam logic [OP_W-1:0] OP_BACK = 2'd2;

    // Calendar limits.
    localparam logic [YEAR_W-1:0]  YEAR_MAX   = 14'd9999;
    localparam logic [YEAR_W-1:0]  YEAR_MIN   = 14'd0;
    localparam logic [MONTH_W-1:0] MONTH_JAN  = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB  = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_DEC  = 4'd12;
    localparam logic [DAY_W-1:0]   DAY_FIRST  = 5'd1;
    localparam logic [DAY_W-1:0]   DAY_LAST   = 5'd31;
    localparam logic [CENT_W-1:0]  YIC_LAST   = 7'd99;

    // Reset date 2000-01-01, kept as century 20, year 0 of that century.
    localparam logic [YEAR_W-1:0]  RESET_YEAR = 14'd2000;
    localparam logic [CENT_W-1:0]  RESET_CENT = 7'd20;

    // floor(y / 100) == (y * 5243) >> 19 for every 14-bit y.
    localparam int RECIP_100_W     = 13;
    localparam int RECIP_100_SHIFT = 19;
    localparam logic [RECIP_100_W-1:0] RECIP_100 = 13'd5243;
    localparam logic [YEAR_W-1:0]  HUNDRED    = 14'd100;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;      // latch the input item, clear the error flag
        logic div_load;     // register the century quotient of the load year
        logic load_commit;  // validate and apply the load
        logic step;         // take one day step
        logic step_back;    // direction of the step
        logic out_load;     // move the current date into the output register
    } gds_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic count_zero;   // no day steps left
        logic at_max;       // date is 9999-12-31
        logic at_min;       // date is 0000-01-01
        logic out_free;     // output register can take a new result
    } gds_status_t;

    // Days in a month; zero for a month code that means nothing.
    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] month,
                                                   input logic leap);
        logic [DAY_W-1:0] len;
        case (month)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                   len = 5'd30;
            4'd2:                                       len = leap ? 5'd29 : 5'd28;
            default:                                    len = 5'd0;
        endcase
        return len;
    endfunction

    // Leap rule from the year split into century and year within century.
    function automatic logic is_leap(input logic [1:0] cent_lo,
                                     input logic [CENT_W-1:0] yic);
        return (yic == '0) ? (cent_lo == 2'd0) : (yic[1:0] == 2'd0);
    endfunction

endpackage

>>> hw/rtl/gds_ctrl.sv
// ----------------------------------------------------------------------------
// gds_ctrl: controller for the date stepper
// One-hot state machine that sequences a load check or a run of day steps
// for one item and hands the result to the output register.
// ----------------------------------------------------------------------------
module gds_ctrl
    import gds_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [OP_W-1:0]       s_opcode,
    input  gds_status_t           status,
    output gds_cmd_t              cmd
);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_LDIV = 5'b00010,
        ST_LCHK = 5'b00100,
        ST_STEP = 5'b01000,
        ST_DONE = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    logic   back_reg, back_next;

    assign s_ready = (state_reg == ST_IDLE);

    // Next state and command decode.
    always_comb begin
        state_next    = state_reg;
        back_next     = back_reg;
        cmd           = '0;
        cmd.step_back = back_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    case (s_opcode)
                        OP_LOAD: state_next = ST_LDIV;
                        OP_ADV: begin
                            back_next  = 1'b0;
                            state_next = ST_STEP;
                        end
                        OP_BACK: begin
                            back_next  = 1'b1;
                            state_next = ST_STEP;
                        end
                        default: state_next = ST_DONE;
                    endcase
                end
            end
            ST_LDIV: begin
                cmd.div_load = 1'b1;
                state_next   = ST_LCHK;
            end
            ST_LCHK: begin
                cmd.load_commit = 1'b1;
                state_next      = ST_DONE;
            end
            ST_STEP: begin
                // A blocked step still issues so that the datapath flags it.
                if (status.count_zero) begin
                    state_next = ST_DONE;
                end else begin
                    cmd.step = 1'b1;
                    if (back_reg ? status.at_min : status.at_max) begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_DONE: begin
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // State registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            back_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            back_reg  <= back_next;
        end
    end

endmodule

>>> hw/rtl/gds_datapath.sv
// ----------------------------------------------------------------------------
// gds_datapath: date registers and day step logic for the date stepper
// Keeps the current date with the year also split into century and year
// within century for the leap rule, the step counter, the load check and
// the output register.
// ----------------------------------------------------------------------------
module gds_datapath
    import gds_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  gds_cmd_t              cmd,
    output gds_status_t           status,
    input  logic [COUNT_W-1:0]    s_day_count,
    input  logic [YEAR_W-1:0]     s_load_year,
    input  logic [MONTH_W-1:0]    s_load_month,
    input  logic [DAY_W-1:0]      s_load_day,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [YEAR_W-1:0]     m_out_year,
    output logic [MONTH_W-1:0]    m_out_month,
    output logic [DAY_W-1:0]      m_out_day,
    output logic                  m_range_error
);

    localparam int PROD_W = YEAR_W + RECIP_100_W;

    // Current date.
    logic [YEAR_W-1:0]  year_reg;
    logic [CENT_W-1:0]  cent_reg;
    logic [CENT_W-1:0]  yic_reg;
    logic [MONTH_W-1:0] month_reg;
    logic [DAY_W-1:0]   day_reg;

    // Item in progress.
    logic [COUNT_W-1:0] count_reg;
    logic [YEAR_W-1:0]  ly_reg;
    logic [MONTH_W-1:0] lm_reg;
    logic [DAY_W-1:0]   ld_reg;
    logic [QUOT_W-1:0]  quot_reg;
    logic               err_reg;

    // Output register.
    logic               m_valid_reg;
    logic [YEAR_W-1:0]  out_year_reg;
    logic [MONTH_W-1:0] out_month_reg;
    logic [DAY_W-1:0]   out_day_reg;
    logic               out_err_reg;

    logic               leap;
    logic [DAY_W-1:0]   cur_len;
    logic [DAY_W-1:0]   prev_len;
    logic [MONTH_W-1:0] prev_month;
    logic [PROD_W-1:0]  prod;
    logic [YEAR_W-1:0]  hundreds;
    logic [YEAR_W-1:0]  ly_rem;
    logic [CENT_W-1:0]  ly_yic;
    logic               ly_leap;
    logic               load_ok;

    // Month lengths for the current year.
    assign leap       = is_leap(cent_reg[1:0], yic_reg);
    assign cur_len    = month_len(month_reg, leap);
    assign prev_month = month_reg - MONTH_JAN;
    assign prev_len   = month_len(prev_month, leap);

    // Century split of the load year: reciprocal multiply, then remainder.
    assign prod     = {{RECIP_100_W{1'b0}}, ly_reg} * {{YEAR_W{1'b0}}, RECIP_100};
    assign hundreds = YEAR_W'({{(YEAR_W-QUOT_W){1'b0}}, quot_reg} * HUNDRED);
    assign ly_rem   = ly_reg - hundreds;
    assign ly_yic   = ly_rem[CENT_W-1:0];
    assign ly_leap  = is_leap(quot_reg[1:0], ly_yic);

    // Load validity check.
    assign load_ok = (ly_reg <= YEAR_MAX) && (lm_reg >= MONTH_JAN) && (lm_reg <= MONTH_DEC)
                   && (ld_reg >= DAY_FIRST) && (ld_reg <= month_len(lm_reg, ly_leap));

    // Status to the controller.
    assign status.count_zero = (count_reg == '0);
    assign status.at_max     = (day_reg == DAY_LAST) && (month_reg == MONTH_DEC)
                             && (year_reg == YEAR_MAX);
    assign status.at_min     = (day_reg == DAY_FIRST) && (month_reg == MONTH_JAN)
                             && (year_reg == YEAR_MIN);
    assign status.out_free   = !m_valid_reg || m_ready;

    // Item capture, quotient and step counter.
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            count_reg <= s_day_count;
            ly_reg    <= s_load_year;
            lm_reg    <= s_load_month;
            ld_reg    <= s_load_day;
        end else if (cmd.step) begin
            count_reg <= count_reg - 1'b1;
        end
        if (cmd.div_load) begin
            quot_reg <= prod[PROD_W-1 -: QUOT_W];
        end
    end

    // Current date and error flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            year_reg  <= RESET_YEAR;
            cent_reg  <= RESET_CENT;
            yic_reg   <= '0;
            month_reg <= MONTH_JAN;
            day_reg   <= DAY_FIRST;
            err_reg   <= 1'b0;
        end else if (cmd.capture) begin
            err_reg <= 1'b0;
        end else if (cmd.load_commit) begin
            if (load_ok) begin
                year_reg  <= ly_reg;
                cent_reg  <= quot_reg[CENT_W-1:0];
                yic_reg   <= ly_yic;
                month_reg <= lm_reg;
                day_reg   <= ld_reg;
            end else begin
                err_reg <= 1'b1;
            end
        end else if (cmd.step && !cmd.step_back) begin
            // One day forward.
            if (day_reg == DAY_LAST && month_reg == MONTH_DEC) begin
                if (year_reg == YEAR_MAX) begin
                    err_reg <= 1'b1;
                end else begin
                    year_reg  <= year_reg + 1'b1;
                    month_reg <= MONTH_JAN;
                    day_reg   <= DAY_FIRST;
                    if (yic_reg == YIC_LAST) begin
                        yic_reg  <= '0;
                        cent_reg <= cent_reg + 1'b1;
                    end else begin
                        yic_reg <= yic_reg + 1'b1;
                    end
                end
            end else if (day_reg >= cur_len) begin
                month_reg <= month_reg + 1'b1;
                day_reg   <= DAY_FIRST;
            end else begin
                day_reg <= day_reg + 1'b1;
            end
        end else if (cmd.step) begin
            // One day back.
            if (day_reg == DAY_FIRST && month_reg == MONTH_JAN) begin
                if (year_reg == YEAR_MIN) begin
                    err_reg <= 1'b1;
                end else begin
                    year_reg  <= year_reg - 1'b1;
                    month_reg <= MONTH_DEC;
                    day_reg   <= DAY_LAST;
                    if (yic_reg == '0) begin
                        yic_reg  <= YIC_LAST;
                        cent_reg <= cent_reg - 1'b1;
                    end else begin
                        yic_reg <= yic_reg - 1'b1;
                    end
                end
            end else if (day_reg <= DAY_FIRST) begin
                month_reg <= prev_month;
                day_reg   <= prev_len;
            end else begin
                day_reg <= day_reg - 1'b1;
            end
        end
    end

    // Output register and its valid flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
        if (cmd.out_load) begin
            out_year_reg  <= year_reg;
            out_month_reg <= month_reg;
            out_day_reg   <= day_reg;
            out_err_reg   <= err_reg;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_out_year    = out_year_reg;
    assign m_out_month   = out_month_reg;
    assign m_out_day     = out_day_reg;
    assign m_range_error = out_err_reg;

endmodule

>>> hw/rtl/gregorian_date_stepper.sv
// A load passes through the capture, century quotient and load check steps before
// its result is written; an advance or go-back takes one day step per cycle in the step loop,
// and a blocked step at either end of the range stops the loop early.
// One item is in work at a time; the input is ready again once the result is
// written to the output register, which waits while an older result is stalled.
// Reset (synchronous, active low) sets the date to 2000-01-01 and empties the output register.
// ----------------------------------------------------------------------------
// gregorian_date_stepper: Gregorian calendar day counter
// Loads a date or moves it forward or back by a count of days, one result
// per item, saturating at 0000-01-01 and 9999-12-31.
// ----------------------------------------------------------------------------
module gregorian_date_stepper
    import gds_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [OP_W-1:0]       s_opcode,
    input  logic [COUNT_W-1:0]    s_day_count,
    input  logic [YEAR_W-1:0]     s_load_year,
    input  logic [MONTH_W-1:0]    s_load_month,
    input  logic [DAY_W-1:0]      s_load_day,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [YEAR_W-1:0]     m_out_year,
    output logic [MONTH_W-1:0]    m_out_month,
    output logic [DAY_W-1:0]      m_out_day,
    output logic                  m_range_error
);

    gds_cmd_t    cmd;
    gds_status_t status;

    // Sequencing.
    gds_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_opcode (s_opcode),
        .status   (status),
        .cmd      (cmd)
    );

    // Date state, step logic and output register.
    gds_datapath u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .status        (status),
        .s_day_count   (s_day_count),
        .s_load_year   (s_load_year),
        .s_load_month  (s_load_month),
        .s_load_day    (s_load_day),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_year    (m_out_year),
        .m_out_month   (m_out_month),
        .m_out_day     (m_out_day),
        .m_range_error (m_range_error)
    );

endmodule

>>> hw/rtl/gds_checker.sv
// ----------------------------------------------------------------------------
// gds_checker: port-level checks for the date stepper
// Watches the top level's ports and checks result ranges, one item at a
// time, reset behavior and result holding.
// ----------------------------------------------------------------------------
module gds_checker
    import gds_pkg::*;
(
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_valid,
    input logic                  s_ready,
    input logic                  m_valid,
    input logic                  m_ready,
    input logic [YEAR_W-1:0]     m_out_year,
    input logic [MONTH_W-1:0]    m_out_month,
    input logic [DAY_W-1:0]      m_out_day
);

    // A result always carries a date inside the calendar range.
    a_date_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_out_year <= YEAR_MAX) && (m_out_month >= MONTH_JAN)
                    && (m_out_month <= MONTH_DEC) && (m_out_day >= DAY_FIRST))
        else $error("result date out of range");

    // Only one item is in work: input is not ready right after a transfer.
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input ready right after an input transfer");

    // Reset empties the output register.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // A stalled result holds its date.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_year)
                                && $stable(m_out_month) && $stable(m_out_day))
        else $error("stalled result changed");

endmodule

bind gregorian_date_stepper gds_checker u_gds_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_valid     (s_valid),
    .s_ready     (s_ready),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_out_year  (m_out_year),
    .m_out_month (m_out_month),
    .m_out_day   (m_out_day)
);
